FILE: rtl/core/epra_pkg.sv
// shared types, constants and widths of the encoder period rpm averager
`timescale 1ns / 1ps

package epra_pkg;

    // field widths
    localparam int TIME_W     = 32;
    localparam int RATE_W     = 28;
    localparam int SPEED_W    = 34;
    localparam int PPR_W      = 13;
    localparam int GEAR_W     = 10;
    localparam int DIVP_W     = PPR_W + GEAR_W;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 13;

    // default ring depth
    localparam int AVG_DEPTH_DEFAULT = 8;

    // arithmetic constants: 1e6 scaled by 2^8, seconds per minute
    localparam logic [RATE_W-1:0] RATE_NUM    = 28'd256000000;
    localparam logic [RATE_W-1:0] RATE_MAX    = '1;
    localparam logic [5:0]        SEC_PER_MIN = 6'd60;

    // register indexes and reset values
    localparam logic [CFG_ADDR_W-1:0] CFG_PULSES_PER_REV = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GEAR_RATIO     = 1'b1;
    localparam logic [PPR_W-1:0]      PPR_RESET          = 13'd11;
    localparam logic [GEAR_W-1:0]     GEAR_RESET         = 10'd71;

    // input word kinds
    localparam logic MODE_EDGE   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // operand selection of the shared divider
    typedef enum logic {
        DIV_RATE,
        DIV_SPEED
    } div_op_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_RATE_GO,
        ST_RATE,
        ST_SPEED_GO,
        ST_SPEED,
        ST_SUM,
        ST_OUT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic    edge_load;
        logic    prep;
        logic    div_start;
        div_op_t div_op;
        logic    rate_load;
        logic    speed_load;
        logic    sum_update;
        logic    out_load;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
    } status_t;

endpackage

FILE: rtl/core/encoder_period_rpm_averager_core.sv
// top level of the encoder period rpm averager
`timescale 1ns / 1ps

// Encoder speed from edge periods with ring averaging. A word with s_mode low
// is an encoder edge: it stores the time since the previous edge (modulo
// 2^32) and gives no result. A word with s_mode high is
// a sample request: rate = 256000000 / period (Hz, Q20.8, saturated with
// m_period_zero set when the period is zero), speed = rate * 60 /
// (pulses_per_rev * gear_ratio) (rpm, Q26.8); both go into rings of AVG_DEPTH
// entries that start out zero, and the result word carries the ring averages.
// One shared restoring divider does the rate and speed divisions at one bit
// per cycle; the averages are the running sums with the low clog2(AVG_DEPTH)
// bits dropped, so AVG_DEPTH must be a power of two. A sample goes through
// PREP, RATE_GO, RATE, SPEED_GO, SPEED, SUM and OUT; OUT waits for the
// previous result to leave the output register. A finished result waits in
// the output register while new words are taken.
// Configuration: cfg_addr 0 = pulses_per_rev, 1 = gear_ratio; a zero divides
// as one. Write only while the block is idle.
module encoder_period_rpm_averager_core #(
    parameter int AVG_DEPTH = epra_pkg::AVG_DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_mode,
    input  logic [epra_pkg::TIME_W-1:0]      s_time_us,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [epra_pkg::RATE_W-1:0]      m_avg_pulse_rate,
    output logic [epra_pkg::SPEED_W-1:0]     m_avg_speed,
    output logic                             m_speed_positive,
    output logic                             m_period_zero,
    input  logic                             cfg_we,
    input  logic [epra_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [epra_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    epra_pkg::cmd_t    cmd;
    epra_pkg::status_t status;

    epra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    epra_datapath #(
        .AVG_DEPTH (AVG_DEPTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_time_us        (s_time_us),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .m_avg_pulse_rate (m_avg_pulse_rate),
        .m_avg_speed      (m_avg_speed),
        .m_speed_positive (m_speed_positive),
        .m_period_zero    (m_period_zero)
    );

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result register loaded while a word still waits");

    // a sample request keeps the input closed in the next cycle
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode) |=> !s_ready)
        else $error("input open right after a sample request");

    // at most one load command per cycle
    a_one_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.edge_load, cmd.rate_load, cmd.speed_load, cmd.sum_update,
                  cmd.out_load}))
        else $error("more than one datapath load in one cycle");

    // an edge word gives no result in the next cycle
    a_edge_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_mode && !m_valid) |=> !m_valid)
        else $error("result appeared after an edge word");

endmodule

FILE: rtl/core/epra_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module epra_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;
    logic             fits;

    // one shift and trial subtract per cycle
    always_comb begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        fits      = rem_shift >= {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[NUM_W-2:0], fits};
            rem_next  = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
            done_next = cnt_reg == CNT_W'(1);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // operands and partial results
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

FILE: rtl/core/epra_datapath.sv
// period capture, rate and speed arithmetic, averaging rings and result registers
`timescale 1ns / 1ps

module epra_datapath #(
    parameter int AVG_DEPTH = epra_pkg::AVG_DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  epra_pkg::cmd_t                     cmd,
    output epra_pkg::status_t                  status,
    input  logic [epra_pkg::TIME_W-1:0]        s_time_us,
    input  logic                               cfg_we,
    input  logic [epra_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [epra_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic [epra_pkg::RATE_W-1:0]        m_avg_pulse_rate,
    output logic [epra_pkg::SPEED_W-1:0]       m_avg_speed,
    output logic                               m_speed_positive,
    output logic                               m_period_zero
);

    localparam int IDX_W   = $clog2(AVG_DEPTH);
    localparam int RSUM_W  = epra_pkg::RATE_W + IDX_W;
    localparam int SSUM_W  = epra_pkg::SPEED_W + IDX_W;
    localparam int NUM_W   = epra_pkg::SPEED_W;
    localparam int DEN_W   = epra_pkg::TIME_W;
    localparam int ENTRY_W = epra_pkg::RATE_W + epra_pkg::SPEED_W;
    localparam int RATE_W  = epra_pkg::RATE_W;
    localparam int SPEED_W = epra_pkg::SPEED_W;

    // configuration
    logic [epra_pkg::PPR_W-1:0]  ppr_reg;
    logic [epra_pkg::GEAR_W-1:0] gear_reg;
    logic [epra_pkg::PPR_W-1:0]  ppr_eff;
    logic [epra_pkg::GEAR_W-1:0] gear_eff;

    // edge timing
    logic [DEN_W-1:0] last_edge_reg;
    logic [DEN_W-1:0] period_reg;

    // per-sample working registers
    logic [epra_pkg::DIVP_W-1:0] divp_reg, divp_next;
    logic                        pz_reg;
    logic [RATE_W-1:0]           rate_reg;
    logic [SPEED_W-1:0]          speed_reg;
    logic [SPEED_W-1:0]          rate_x60;

    // rings and running sums
    logic [ENTRY_W-1:0]   ring_mem [AVG_DEPTH];
    logic [ENTRY_W-1:0]   rd_reg;
    logic                 rd_valid_reg;
    logic [AVG_DEPTH-1:0] valid_reg;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [RSUM_W-1:0]    rate_sum_reg, rate_sum_next;
    logic [SSUM_W-1:0]    speed_sum_reg, speed_sum_next;
    logic [RATE_W-1:0]    old_rate;
    logic [SPEED_W-1:0]   old_speed;

    // result registers
    logic [RATE_W-1:0]  out_rate_reg;
    logic [SPEED_W-1:0] out_speed_reg;
    logic               out_pos_reg;
    logic               out_pz_reg;

    // divider hookup
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [NUM_W-1:0] div_quo;
    logic             div_done;

    // zero divisor registers divide as one
    always_comb begin
        ppr_eff   = (ppr_reg == '0) ? epra_pkg::PPR_W'(1) : ppr_reg;
        gear_eff  = (gear_reg == '0) ? epra_pkg::GEAR_W'(1) : gear_reg;
        divp_next = epra_pkg::DIVP_W'(ppr_eff) * epra_pkg::DIVP_W'(gear_eff);
        rate_x60  = SPEED_W'(rate_reg) * SPEED_W'(epra_pkg::SEC_PER_MIN);
    end

    // divider operand selection
    always_comb begin
        case (cmd.div_op)
            epra_pkg::DIV_RATE: begin
                div_num = NUM_W'(epra_pkg::RATE_NUM);
                div_den = period_reg;
            end
            epra_pkg::DIV_SPEED: begin
                div_num = NUM_W'(rate_x60);
                div_den = DEN_W'(divp_reg);
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    epra_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .done    (div_done)
    );

    assign status.div_done = div_done;

    // running sums: drop the overwritten entry, add the new one
    always_comb begin
        old_rate       = rd_valid_reg ? rd_reg[RATE_W-1:0] : '0;
        old_speed      = rd_valid_reg ? rd_reg[ENTRY_W-1:RATE_W] : '0;
        rate_sum_next  = rate_sum_reg - RSUM_W'(old_rate) + RSUM_W'(rate_reg);
        speed_sum_next = speed_sum_reg - SSUM_W'(old_speed) + SSUM_W'(speed_reg);
        idx_next       = (idx_reg == IDX_W'(AVG_DEPTH - 1)) ? '0 : idx_reg + IDX_W'(1);
    end

    // configuration, edge timing, ring pointer, sums and valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppr_reg       <= epra_pkg::PPR_RESET;
            gear_reg      <= epra_pkg::GEAR_RESET;
            last_edge_reg <= '0;
            period_reg    <= '0;
            idx_reg       <= '0;
            rate_sum_reg  <= '0;
            speed_sum_reg <= '0;
            valid_reg     <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    epra_pkg::CFG_PULSES_PER_REV: ppr_reg <= cfg_wdata;
                    epra_pkg::CFG_GEAR_RATIO:     gear_reg <= cfg_wdata[epra_pkg::GEAR_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.edge_load) begin
                period_reg    <= s_time_us - last_edge_reg;
                last_edge_reg <= s_time_us;
            end
            if (cmd.sum_update) begin
                rate_sum_reg       <= rate_sum_next;
                speed_sum_reg      <= speed_sum_next;
                valid_reg[idx_reg] <= 1'b1;
                idx_reg            <= idx_next;
            end
        end
    end

    // ring storage, one write and one registered read
    always_ff @(posedge aclk) begin
        if (cmd.sum_update) begin
            ring_mem[idx_reg] <= {speed_reg, rate_reg};
        end
        if (cmd.prep) begin
            rd_reg <= ring_mem[idx_reg];
        end
    end

    // per-sample working values and results; averages drop the low index bits
    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            divp_reg     <= divp_next;
            pz_reg       <= period_reg == '0;
            rd_valid_reg <= valid_reg[idx_reg];
        end
        if (cmd.rate_load) begin
            rate_reg <= pz_reg ? epra_pkg::RATE_MAX : div_quo[RATE_W-1:0];
        end
        if (cmd.speed_load) begin
            speed_reg <= div_quo[SPEED_W-1:0];
        end
        if (cmd.out_load) begin
            out_rate_reg  <= rate_sum_reg[RSUM_W-1:IDX_W];
            out_speed_reg <= speed_sum_reg[SSUM_W-1:IDX_W];
            out_pos_reg   <= speed_reg != '0;
            out_pz_reg    <= pz_reg;
        end
    end

    assign m_avg_pulse_rate = out_rate_reg;
    assign m_avg_speed      = out_speed_reg;
    assign m_speed_positive = out_pos_reg;
    assign m_period_zero    = out_pz_reg;

endmodule

FILE: rtl/core/epra_ctrl.sv
// sequencing state machine and output handshake
`timescale 1ns / 1ps

module epra_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_mode,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output epra_pkg::cmd_t    cmd,
    input  epra_pkg::status_t status
);

    epra_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    // state and result-valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= epra_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = state_reg == epra_pkg::ST_IDLE;
        case (state_reg)
            epra_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_mode == epra_pkg::MODE_SAMPLE) begin
                        state_next = epra_pkg::ST_PREP;
                    end else begin
                        cmd.edge_load = 1'b1;
                    end
                end
            end
            epra_pkg::ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = epra_pkg::ST_RATE_GO;
            end
            epra_pkg::ST_RATE_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = epra_pkg::DIV_RATE;
                state_next    = epra_pkg::ST_RATE;
            end
            epra_pkg::ST_RATE: begin
                if (status.div_done) begin
                    cmd.rate_load = 1'b1;
                    state_next    = epra_pkg::ST_SPEED_GO;
                end
            end
            epra_pkg::ST_SPEED_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = epra_pkg::DIV_SPEED;
                state_next    = epra_pkg::ST_SPEED;
            end
            epra_pkg::ST_SPEED: begin
                if (status.div_done) begin
                    cmd.speed_load = 1'b1;
                    state_next     = epra_pkg::ST_SUM;
                end
            end
            epra_pkg::ST_SUM: begin
                cmd.sum_update = 1'b1;
                state_next     = epra_pkg::ST_OUT;
            end
            epra_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = epra_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = epra_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: tb/sv/tb_encoder_period_rpm_averager_core.sv
// self-checking testbench of the encoder period rpm averager core
`timescale 1ns / 1ps

module tb_encoder_period_rpm_averager_core;

    localparam int DEPTH      = epra_pkg::AVG_DEPTH_DEFAULT;
    localparam int TIME_W     = epra_pkg::TIME_W;
    localparam int RATE_W     = epra_pkg::RATE_W;
    localparam int SPEED_W    = epra_pkg::SPEED_W;
    localparam int PPR_W      = epra_pkg::PPR_W;
    localparam int GEAR_W     = epra_pkg::GEAR_W;
    localparam int CFG_ADDR_W = epra_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = epra_pkg::CFG_DATA_W;
    localparam int SETTLE     = 200;
    localparam int STALL_MAX  = 4000;  // cycles with no word moved on either side
    localparam int PHASES     = 7;
    localparam int PHASE_LEN  = 165;
    localparam int PRINT_MAX  = 50;

    // one averaged result word
    typedef struct {
        logic [RATE_W-1:0]  rate;
        logic [SPEED_W-1:0] speed;
        logic               positive;
        logic               zero_period;
    } rpm_result_t;

    // speed predictor and store of expected averages
    class rpm_scoreboard;
        logic [PPR_W-1:0]   ppr;
        logic [GEAR_W-1:0]  gear;
        logic [TIME_W-1:0]  last_edge;
        logic [TIME_W-1:0]  period;
        logic [RATE_W-1:0]  rate_hist[DEPTH];
        logic [SPEED_W-1:0] speed_hist[DEPTH];
        int unsigned        slot;
        longint unsigned    rate_total;
        longint unsigned    speed_total;
        rpm_result_t        pending[$];
        int                 errors;

        function new();
            ppr         = epra_pkg::PPR_RESET;
            gear        = epra_pkg::GEAR_RESET;
            last_edge   = '0;
            period      = '0;
            slot        = 0;
            rate_total  = 0;
            speed_total = 0;
            errors      = 0;
            for (int i = 0; i < DEPTH; i++) begin
                rate_hist[i]  = '0;
                speed_hist[i] = '0;
            end
        endfunction

        // register write; gear ratio keeps its low bits only
        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            if (addr == epra_pkg::CFG_PULSES_PER_REV) begin
                ppr = data[PPR_W-1:0];
            end else if (addr == epra_pkg::CFG_GEAR_RATIO) begin
                gear = data[GEAR_W-1:0];
            end
        endfunction

        // accepted input word: edges update the period, samples expect a result
        function void note_word(logic mode, logic [TIME_W-1:0] stamp);
            rpm_result_t     res;
            longint unsigned rate;
            longint unsigned speed;
            longint unsigned divisor;
            longint unsigned num;
            longint unsigned sat;
            if (mode == epra_pkg::MODE_EDGE) begin
                period    = stamp - last_edge;
                last_edge = stamp;
                return;
            end
            num = epra_pkg::RATE_NUM;
            sat = epra_pkg::RATE_MAX;
            if (period == 0) begin
                rate = sat;
            end else begin
                rate = num / period;
                if (rate > sat) rate = sat;
            end
            // zero registers divide as one
            divisor = (ppr == 0 ? 64'd1 : 64'(ppr)) * (gear == 0 ? 64'd1 : 64'(gear));
            speed   = (rate * epra_pkg::SEC_PER_MIN) / divisor;
            speed   = speed & ((64'd1 << SPEED_W) - 1);
            // running sums over the ring
            rate_total  = rate_total - rate_hist[slot] + rate;
            speed_total = speed_total - speed_hist[slot] + speed;
            rate_hist[slot]  = rate[RATE_W-1:0];
            speed_hist[slot] = speed[SPEED_W-1:0];
            slot = (slot + 1) % DEPTH;
            res.rate        = RATE_W'(rate_total / DEPTH);
            res.speed       = SPEED_W'(speed_total / DEPTH);
            res.positive    = (speed > 0);
            res.zero_period = (period == 0);
            pending.push_back(res);
        endfunction

        task report_miss(string what);
            errors++;
            if (errors <= PRINT_MAX) $display("%0t mismatch: %s", $realtime, what);
        endtask

        // accepted result word against the oldest expectation
        task check_result(rpm_result_t got);
            rpm_result_t exp;
            if (pending.size() == 0) begin
                report_miss("result word with no sample waiting");
            end else begin
                exp = pending.pop_front();
                if (got.rate !== exp.rate)
                    report_miss($sformatf("avg_pulse_rate %0h, expected %0h", got.rate, exp.rate));
                if (got.speed !== exp.speed)
                    report_miss($sformatf("avg_speed %0h, expected %0h", got.speed, exp.speed));
                if (got.positive !== exp.positive)
                    report_miss($sformatf("speed_positive %b, expected %b",
                                          got.positive, exp.positive));
                if (got.zero_period !== exp.zero_period)
                    report_miss($sformatf("period_zero %b, expected %b",
                                          got.zero_period, exp.zero_period));
            end
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_mode    = epra_pkg::MODE_EDGE;
    logic [TIME_W-1:0]     s_time_us = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [RATE_W-1:0]     m_avg_pulse_rate;
    logic [SPEED_W-1:0]    m_avg_speed;
    logic                  m_speed_positive;
    logic                  m_period_zero;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    rpm_scoreboard     sb = new();
    logic              gaps_on = 1'b1;
    logic [TIME_W-1:0] edge_stamp = '0;
    int                quiet_cycles = 0;

    encoder_period_rpm_averager_core #(
        .AVG_DEPTH(DEPTH)
    ) uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_time_us       (s_time_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_avg_pulse_rate(m_avg_pulse_rate),
        .m_avg_speed     (m_avg_speed),
        .m_speed_positive(m_speed_positive),
        .m_period_zero   (m_period_zero),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // result side back-pressure
    always @(negedge aclk) begin
        m_ready <= gaps_on ? ($urandom_range(99) >= 28) : 1'b1;
    end

    // result monitor
    always @(posedge aclk) begin
        rpm_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.rate        = m_avg_pulse_rate;
            got.speed       = m_avg_speed;
            got.positive    = m_speed_positive;
            got.zero_period = m_period_zero;
            sb.check_result(got);
        end
    end

    // watchdog on cycles with no word moved
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("tb_encoder_period_rpm_averager_core NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // hand one word to the block; called and returning at a falling edge
    task automatic push_word(input logic mode, input logic [TIME_W-1:0] stamp);
        if (gaps_on && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < 28);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_time_us <= stamp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_word(mode, stamp);
        @(negedge aclk);
    endtask

    task automatic push_edge(input logic [TIME_W-1:0] stamp);
        edge_stamp = stamp;
        push_word(epra_pkg::MODE_EDGE, stamp);
    endtask

    // hold the input until every pending average is out, then let the core settle
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] ppr_data,
                              input logic [CFG_DATA_W-1:0] gear_data);
        cfg_we    <= 1'b1;
        cfg_addr  <= epra_pkg::CFG_PULSES_PER_REV;
        cfg_wdata <= ppr_data;
        @(negedge aclk);
        sb.set_reg(epra_pkg::CFG_PULSES_PER_REV, ppr_data);
        cfg_addr  <= epra_pkg::CFG_GEAR_RATIO;
        cfg_wdata <= gear_data;
        @(negedge aclk);
        sb.set_reg(epra_pkg::CFG_GEAR_RATIO, gear_data);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // random word: samples or edges with short, long, wrapped and zero periods
    task automatic random_word();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            push_word(epra_pkg::MODE_SAMPLE, $urandom());
        end else begin
            pick = $urandom_range(99);
            if (pick < 6)
                push_edge(edge_stamp);
            else if (pick < 45)
                push_edge(edge_stamp + $urandom_range(2000, 1));
            else if (pick < 75)
                push_edge(edge_stamp + $urandom_range(1 << 20, 2001));
            else
                push_edge($urandom());
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] ppr_tab[PHASES];
        logic [CFG_DATA_W-1:0] gear_tab[PHASES];

        // register settings per phase; phase 0 runs on reset values
        ppr_tab  = '{13'd11, 13'd1, 13'h1FFF, 13'd0,    13'd4096, 13'd0, 13'd11};
        gear_tab = '{13'd71, 13'd1, 13'h1FFF, 13'h1C00, 13'd1023, 13'd0, 13'd71};
        ppr_tab[5]  = CFG_DATA_W'($urandom_range(8191));
        gear_tab[5] = CFG_DATA_W'($urandom());

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed words on reset values
        push_word(epra_pkg::MODE_SAMPLE, 32'h0);          // sample before any edge
        push_edge(32'h0);                                 // first edge at time zero
        push_word(epra_pkg::MODE_SAMPLE, 32'hFFFF_FFFF);
        push_edge(32'h1);                                 // shortest period
        push_word(epra_pkg::MODE_SAMPLE, 32'h0);
        push_edge(32'hFFFF_FFFF);                         // period of 0xFFFFFFFE, rate drops to zero
        push_word(epra_pkg::MODE_SAMPLE, 32'h0);
        push_edge(32'h2);                                 // period across the wrap
        push_word(epra_pkg::MODE_SAMPLE, 32'h0);
        push_edge(32'hAAAA_AAAA);
        push_edge(32'h5555_5555);
        push_word(epra_pkg::MODE_SAMPLE, 32'h5555_5555);
        push_edge(32'h5555_5555);                         // edge at the same time as the previous one, period zero
        push_word(epra_pkg::MODE_SAMPLE, 32'hAAAA_AAAA);
        push_edge(32'h5555_5555 + 2000);
        push_word(epra_pkg::MODE_SAMPLE, 32'h0);
        push_edge(32'h5555_5555 + 2100);
        push_word(epra_pkg::MODE_SAMPLE, 32'h0);          // ring wraps around from here
        push_word(epra_pkg::MODE_SAMPLE, 32'h0);
        push_word(epra_pkg::MODE_SAMPLE, 32'h0);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain_results();
                write_regs(ppr_tab[ph], gear_tab[ph]);
            end
            // one whole phase with no gaps on either side
            gaps_on = (ph != 2);
            for (int n = 0; n < PHASE_LEN; n++) begin
                if (ph == 1 && n == PHASE_LEN / 2) drain_results();
                random_word();
            end
        end

        gaps_on = 1'b1;
        drain_results();

        if (sb.errors == 0) begin
            $display("tb_encoder_period_rpm_averager_core OK");
        end else begin
            $display("tb_encoder_period_rpm_averager_core NOT OK");
        end
        $finish;
    end

endmodule
